>>> design/sml_pkg.sv
// ----------------------------------------------------------------------------
// sml_pkg
// Shared constants, codes and types for the sorted multiset list.
// ----------------------------------------------------------------------------
package sml_pkg;

	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int IDX_W    = 5;
	localparam int TYPE_W   = 2;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 6;

	// request codes
	localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_READ   = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

	// broadcast to every cell
	typedef struct packed {
		logic                     insert;  // insert taken, store not full
		logic                     remove;  // remove taken, value present
		logic signed [VAL_W-1:0]  value;
	} cell_ctl_t;

	// per-cell flags seen by the neighbours and the top level
	typedef struct packed {
		logic ins_mark;  // empty, or holds a value above the request value
		logic rm_mark;   // occupied and holds a value at or above it
		logic hit;       // occupied and equal
	} cell_flags_t;

endpackage

>>> design/sml_req_if.sv
// ----------------------------------------------------------------------------
// sml_req_if
// Request channel: valid/ready handshake with request type, value and index.
// ----------------------------------------------------------------------------
interface sml_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] value;
	logic [4:0]         index;

	modport source (output valid, req_type, value, index, input ready);
	modport sink (input valid, req_type, value, index, output ready);
endinterface

>>> design/sml_rsp_if.sv
// ----------------------------------------------------------------------------
// sml_rsp_if
// Result channel: valid/ready handshake with status, read value and count.
// ----------------------------------------------------------------------------
interface sml_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] read_value;
	logic [5:0]         entry_count;

	modport source (output valid, status, read_value, entry_count, input ready);
	modport sink (input valid, status, read_value, entry_count, output ready);
endinterface

>>> design/sml_cell.sv
// ----------------------------------------------------------------------------
// sml_cell
// One slot of the sorted row: holds an entry, compares it with the request
// value and shifts right on insert or left on remove.
// ----------------------------------------------------------------------------
module sml_cell (
	input  logic                        clk,
	input  sml_pkg::cell_ctl_t          ctl,
	input  logic                        occupied,
	input  logic signed [31:0]          left_entry,
	input  logic                        left_ins_mark,
	input  logic signed [31:0]          right_entry,
	output logic signed [31:0]          entry,
	output sml_pkg::cell_flags_t        flags
);
	import sml_pkg::*;

	logic signed [VAL_W-1:0] entry_q;

	assign entry          = entry_q;
	assign flags.ins_mark = !occupied || (entry_q > ctl.value);
	assign flags.rm_mark  = occupied && (entry_q >= ctl.value);
	assign flags.hit      = occupied && (entry_q == ctl.value);

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (ctl.insert && flags.ins_mark) begin
			entry_q <= left_ins_mark ? left_entry : ctl.value;
		end else if (ctl.remove && flags.rm_mark) begin
			entry_q <= right_entry;
		end
	end

endmodule

>>> design/sorted_multiset_list.sv
// ----------------------------------------------------------------------------
// sorted_multiset_list
// Bounded ascending multiset of signed 32-bit values kept in a row of cells.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                               | handshake
//  --------+-----+--------------------------------------+-------------
//  req     | in  | req_type, value, index               | valid/ready
//  rsp     | out | status, read_value, entry_count      | valid/ready
//
//  Every cell compares against the request value at once and shifts at the
//  accepting edge; the result lands in the output register at that same
//  edge. Sustained rate is one item per cycle while rsp.ready stays high,
//  set by the single output register.
//  req.ready drops only while a result sits in the output register and
//  rsp.ready is low.
//  arst_n clears the fill count and output valid; entries need no reset since
//  only slots below the fill count are ever read.
//
module sorted_multiset_list (
	input  logic     clk,
	input  logic     arst_n,
	sml_req_if.sink  req,
	sml_rsp_if.source rsp
);
	import sml_pkg::*;

	logic [CNT_W-1:0]        fill_q;
	logic                    out_valid_q;
	logic [STAT_W-1:0]       status_q;
	logic signed [VAL_W-1:0] read_value_q;

	logic signed [VAL_W-1:0] entries   [CAPACITY];
	cell_flags_t             flags     [CAPACITY];
	logic [CAPACITY-1:0]     hit_vec;

	cell_ctl_t               ctl;
	logic                    accept;
	logic                    full;
	logic                    found;
	logic                    idx_ok;
	logic [STAT_W-1:0]       status_d;
	logic signed [VAL_W-1:0] read_value_d;
	logic [CNT_W-1:0]        fill_d;

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (fill_q >= CNT_W'(CAPACITY));
	assign found     = |hit_vec;
	assign idx_ok    = (CNT_W'(req.index) < fill_q) && (32'(req.index) < 32'(CAPACITY));

	assign ctl.value  = req.value;
	assign ctl.insert = accept && (req.req_type == REQ_INSERT) && !full;
	assign ctl.remove = accept && (req.req_type == REQ_REMOVE) && found;

	// the row: insert shifts right from the first mark, remove shifts left
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_e;
		logic signed [VAL_W-1:0] right_e;
		logic                    left_m;

		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_m = 1'b0;
		end else begin : g_mid
			assign left_e = entries[i-1];
			assign left_m = flags[i-1].ins_mark;
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = entries[i];
		end else begin : g_inner
			assign right_e = entries[i+1];
		end

		sml_cell u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.occupied     (CNT_W'(i) < fill_q),
			.left_entry   (left_e),
			.left_ins_mark(left_m),
			.right_entry  (right_e),
			.entry        (entries[i]),
			.flags        (flags[i])
		);

		assign hit_vec[i] = flags[i].hit;
	end

	// result and next fill
	always_comb begin
		status_d     = ST_OK;
		read_value_d = '0;
		fill_d       = fill_q;
		unique case (req.req_type)
			REQ_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					fill_d = fill_q + CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (found) begin
					fill_d = fill_q - CNT_W'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			REQ_READ: begin
				if (idx_ok) begin
					read_value_d = entries[req.index];
				end else begin
					status_d = ST_BAD_INDEX;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_d;
			read_value_q <= read_value_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.entry_count = COUNT_W'(fill_q);

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.req_type == REQ_INSERT) && full
		|=> (status_q == ST_FULL) && $stable(fill_q))
		else $error("insert into full store not dropped");

	a_miss_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.req_type == REQ_REMOVE) && !found
		|=> (status_q == ST_NOT_FOUND) && $stable(fill_q))
		else $error("remove of absent value changed the store");

	a_bad_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.req_type == REQ_READ) && !idx_ok
		|=> (status_q == ST_BAD_INDEX) && (read_value_q == '0))
		else $error("out of range read not flagged");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert |=> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("insert did not grow fill count");

endmodule

>>> tb/sorted_multiset_list_test.sv
// ----------------------------------------------------------------------------
// sorted_multiset_list_test
// Self-checking bench for the sorted multiset list. A directed table covers
// the empty store, the value extremes, duplicates, misses, out-of-range
// reads and the unused request code. Random fill, drain and mixed runs
// follow, under several idle and stall mixes, with two long output hold-offs.
// Every result is checked against a queue-based model or a typed outcome.
// ----------------------------------------------------------------------------
module sorted_multiset_list_test;

	timeunit 1ns;
	timeprecision 1ps;

	import sml_pkg::*;

	typedef logic signed [VAL_W-1:0] word_t;

	// the one request code the package leaves unnamed: a no-op
	localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

	localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
	localparam word_t WORD_MIN = 32'sh8000_0000;
	localparam word_t WORD_NEG1 = 32'shFFFF_FFFF;

	localparam int ROWS = 23;
	localparam int PHASES = 5;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_LIMIT = 1000;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		word_t              read_value;
		logic [COUNT_W-1:0] entry_count;
	} outcome_t;

	typedef struct packed {
		logic [TYPE_W-1:0] kind;
		word_t             value;
		logic [IDX_W-1:0]  index;
		logic              typed;  // row carries a hand-written outcome
		outcome_t          want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	sml_req_if req_ch();
	sml_rsp_if rsp_ch();

	sorted_multiset_list u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// model of the store: kept ascending, equal values in arrival order
	word_t    shelf_q[$];
	outcome_t pending_q[$];

	int  errors;
	int  items_sent;
	int  src_idle_pct;
	int  sink_stall_pct;
	bit  hold_request;

	// idle mixes per phase: none, sender gaps, receiver stalls, both, none
	int idle_plan[PHASES]  = '{0, 52, 0, 23, 0};
	int stall_plan[PHASES] = '{0, 0, 52, 23, 0};

	// Directed table. Outcomes are typed in only where they are obvious;
	// the rest come from the model.
	stim_row_t directed_tbl[ROWS] = '{
		// empty store: read misses, remove misses, unused code does nothing
		'{REQ_READ,   32'sd0,         5'd0,  1'b1, '{ST_BAD_INDEX, 32'sd0, 6'd0}},
		'{REQ_REMOVE, 32'sd5,         5'd0,  1'b1, '{ST_NOT_FOUND, 32'sd0, 6'd0}},
		'{REQ_UNUSED, 32'sh1234_5678, 5'd17, 1'b1, '{ST_OK,        32'sd0, 6'd0}},
		// extremes go in
		'{REQ_INSERT, WORD_MAX,       5'd0,  1'b1, '{ST_OK,        32'sd0, 6'd1}},
		'{REQ_INSERT, WORD_MIN,       5'd31, 1'b1, '{ST_OK,        32'sd0, 6'd2}},
		// duplicates and values either side of zero
		'{REQ_INSERT, 32'sd0,         5'd0,  1'b0, '0},
		'{REQ_INSERT, 32'sd0,         5'd9,  1'b0, '0},
		'{REQ_INSERT, WORD_NEG1,      5'd0,  1'b0, '0},
		'{REQ_INSERT, 32'sd1,         5'd0,  1'b0, '0},
		// ends of the list, then just past the fill and the top index
		'{REQ_READ,   32'sd0,         5'd0,  1'b1, '{ST_OK,        WORD_MIN, 6'd6}},
		'{REQ_READ,   32'sd0,         5'd5,  1'b1, '{ST_OK,        WORD_MAX, 6'd6}},
		'{REQ_READ,   32'sd0,         5'd6,  1'b1, '{ST_BAD_INDEX, 32'sd0,   6'd6}},
		'{REQ_READ,   WORD_NEG1,      5'd31, 1'b1, '{ST_BAD_INDEX, 32'sd0,   6'd6}},
		'{REQ_READ,   32'sd0,         5'd2,  1'b0, '0},
		// removes: one of a pair, a miss between entries, both extremes
		'{REQ_REMOVE, 32'sd0,         5'd0,  1'b0, '0},
		'{REQ_REMOVE, 32'sd2,         5'd0,  1'b1, '{ST_NOT_FOUND, 32'sd0,   6'd5}},
		'{REQ_REMOVE, WORD_MIN,       5'd0,  1'b0, '0},
		'{REQ_REMOVE, WORD_MAX,       5'd0,  1'b0, '0},
		'{REQ_REMOVE, WORD_NEG1,      5'd0,  1'b0, '0},
		'{REQ_READ,   32'sd0,         5'd0,  1'b0, '0},
		'{REQ_INSERT, WORD_MIN,       5'd31, 1'b0, '0},
		'{REQ_REMOVE, WORD_MAX,       5'd0,  1'b1, '{ST_NOT_FOUND, 32'sd0,   6'd3}},
		'{REQ_UNUSED, WORD_NEG1,      5'd31, 1'b0, '0}
	};

	// ------------------------------------------------------------------
	// Clock, reset and the run limit
	// ------------------------------------------------------------------
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#2ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Store model: applies one request, returns the outcome it gives
	// ------------------------------------------------------------------
	function automatic outcome_t apply_request(input logic [TYPE_W-1:0] kind,
			input word_t value, input logic [IDX_W-1:0] index);
		outcome_t res;
		int       pos;
		res = '0;
		case (kind)
			REQ_INSERT: begin
				if (shelf_q.size() >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					// after every equal entry, before the first larger one
					pos = shelf_q.size();
					for (int i = 0; i < shelf_q.size(); i++) begin
						if (shelf_q[i] > value) begin
							pos = i;
							break;
						end
					end
					shelf_q.insert(pos, value);
				end
			end
			REQ_REMOVE: begin
				res.status = ST_NOT_FOUND;
				for (int i = 0; i < shelf_q.size(); i++) begin
					if (shelf_q[i] == value) begin
						shelf_q.delete(i);
						res.status = ST_OK;
						break;
					end
				end
			end
			REQ_READ: begin
				if (index < shelf_q.size())
					res.read_value = shelf_q[index];
				else
					res.status = ST_BAD_INDEX;
			end
			default: begin
				// unused code: no change, plain OK
			end
		endcase
		res.entry_count = COUNT_W'(shelf_q.size());
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offers one item and waits for it to be taken. The model runs at the
	// accepting edge, so its state always matches what the block has seen.
	task automatic send_item(input logic [TYPE_W-1:0] kind, input word_t value,
			input logic [IDX_W-1:0] index, input bit typed, input outcome_t want);
		outcome_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.value    <= value;
		req_ch.index    <= index;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		predicted = apply_request(kind, value, index);
		pending_q.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// small values often, so duplicates and hits are common
	function automatic word_t any_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return WORD_MIN;
					1: return WORD_MAX;
					2: return WORD_NEG1;
					default: return 32'sd0;
				endcase
			end
			1, 2, 3, 4: return word_t'($urandom_range(0, 15)) - 32'sd8;
			default: return word_t'($urandom);
		endcase
	endfunction

	// a value that is stored, where there is one, most of the time
	function automatic word_t stored_value();
		if (shelf_q.size() != 0 && $urandom_range(0, 9) < 7)
			return shelf_q[$urandom_range(0, shelf_q.size() - 1)];
		return any_value();
	endfunction

	function automatic logic [IDX_W-1:0] any_index();
		if (shelf_q.size() != 0 && $urandom_range(0, 1) == 0)
			return IDX_W'($urandom_range(0, shelf_q.size() - 1));
		return IDX_W'($urandom_range(0, 31));
	endfunction

	// insert until full, then a few more that must be dropped
	task automatic fill_run();
		int n;
		n = CAPACITY - shelf_q.size() + $urandom_range(1, 3);
		repeat (n)
			send_item(REQ_INSERT, any_value(), any_index(), 1'b0, '0);
	endtask

	// remove stored values until empty, with the odd read or miss mixed in
	task automatic drain_run();
		while (shelf_q.size() != 0) begin
			case ($urandom_range(0, 7))
				0: send_item(REQ_READ, any_value(), any_index(), 1'b0, '0);
				1: send_item(REQ_REMOVE, any_value(), any_index(), 1'b0, '0);
				default: send_item(REQ_REMOVE,
					shelf_q[$urandom_range(0, shelf_q.size() - 1)],
					any_index(), 1'b0, '0);
			endcase
		end
		repeat ($urandom_range(1, 2))
			send_item(REQ_REMOVE, any_value(), any_index(), 1'b0, '0);
	endtask

	task automatic mixed_run();
		int pick;
		repeat (20) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				send_item(REQ_INSERT, any_value(), any_index(), 1'b0, '0);
			else if (pick < 65)
				send_item(REQ_REMOVE, stored_value(), any_index(), 1'b0, '0);
			else if (pick < 95)
				send_item(REQ_READ, any_value(), any_index(), 1'b0, '0);
			else
				send_item(REQ_UNUSED, any_value(), any_index(), 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		int drain_cycles;
		errors         = 0;
		items_sent     = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_request   = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_INSERT;
		req_ch.value    = '0;
		req_ch.index    = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_tbl[r])
			send_item(directed_tbl[r].kind, directed_tbl[r].value,
				directed_tbl[r].index, directed_tbl[r].typed, directed_tbl[r].want);

		// random part: the first run always fills the store to overflow
		fill_run();
		for (int p = 0; p < PHASES; p++) begin
			src_idle_pct   = idle_plan[p];
			sink_stall_pct = stall_plan[p];
			// long output hold-off while items keep coming: input must stall
			if (p == 0 || p == 3)
				hold_request = 1'b1;
			while (items_sent < ROWS + (p + 1) * ITEMS_PER_PHASE) begin
				case ($urandom_range(0, 3))
					0: fill_run();
					1: drain_run();
					default: mixed_run();
				endcase
			end
		end
		req_ch.valid <= 1'b0;

		// let outstanding results arrive, then a short tail for strays
		drain_cycles = 0;
		while (pending_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (8) @(posedge clk);
		if (pending_q.size() != 0) begin
			$display("%0t: %0d result(s) never arrived", $time, pending_q.size());
			errors++;
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: checks each taken item against the oldest expectation
	// ------------------------------------------------------------------
	initial begin : result_sink
		outcome_t want;
		int       hold_left;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (pending_q.size() == 0) begin
					$display("%0t: result with nothing expected: expected none, got status %0d",
						$time, rsp_ch.status);
					errors++;
				end else begin
					want = pending_q.pop_front();
					if (rsp_ch.status !== want.status) begin
						$display("%0t: status: expected %0d, got %0d",
							$time, want.status, rsp_ch.status);
						errors++;
					end
					if (rsp_ch.read_value !== want.read_value) begin
						$display("%0t: read_value: expected %0d, got %0d",
							$time, want.read_value, rsp_ch.read_value);
						errors++;
					end
					if (rsp_ch.entry_count !== want.entry_count) begin
						$display("%0t: entry_count: expected %0d, got %0d",
							$time, want.entry_count, rsp_ch.entry_count);
						errors++;
					end
				end
			end

			// ready for the next edge: hold-off first, else random stalls
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

endmodule
